[rtl/peta_pkg.sv]
// Shared types and constants of the pointer event transform accumulator.
package peta_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] RegFlags = 3'd0;
    localparam logic [CfgIdxW-1:0] RegNum = 3'd1;
    localparam logic [CfgIdxW-1:0] RegDen = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCos = 3'd3;
    localparam logic [CfgIdxW-1:0] RegSin = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRtype = 3'd5;
    localparam logic [CfgIdxW-1:0] RegRcodes = 3'd6;
    localparam logic [CfgIdxW-1:0] RegLayer = 3'd7;

    localparam logic [4:0] TypeKey = 5'd1;
    localparam logic [4:0] TypeRel = 5'd2;

    localparam logic [9:0] CodeRelX = 10'd0;
    localparam logic [9:0] CodeRelY = 10'd1;
    localparam logic [9:0] CodeHwheel = 10'd6;
    localparam logic [9:0] CodeWheel = 10'd8;
    localparam logic [9:0] CodeBtn0 = 10'd256;

    localparam int unsigned MaskW = 5;

    typedef enum logic [2:0] {
        t_op_none,
        t_op_mx,
        t_op_my,
        t_op_sx,
        t_op_sy,
        t_op_btn
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [2:0]        btn;
        logic signed [16:0] value;
        logic              sync;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] motion_x;
        logic signed [15:0] motion_y;
        logic              motion_valid;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
        logic              scroll_valid;
        logic [MaskW-1:0]  pressed_buttons;
        logic [MaskW-1:0]  released_buttons;
    } t_report;

endpackage

[rtl/peta_if.sv]
// Valid/ready channel interfaces for events and reports.
interface peta_event_if;
    logic              valid;
    logic              ready;
    logic [4:0]        event_type;
    logic [9:0]        event_code;
    logic signed [15:0] event_value;
    logic              sync_mark;
    logic              device_present;
    logic [4:0]        active_layer;
    logic              stop_verdict;
    modport source(output valid, event_type, event_code, event_value, sync_mark,
                   device_present, active_layer, stop_verdict, input ready);
    modport sink(input valid, event_type, event_code, event_value, sync_mark,
                 device_present, active_layer, stop_verdict, output ready);
endinterface

interface peta_report_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] motion_x;
    logic signed [15:0] motion_y;
    logic              motion_valid;
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;
    logic              scroll_valid;
    logic [4:0]        pressed_buttons;
    logic [4:0]        released_buttons;
    modport source(output valid, motion_x, motion_y, motion_valid, scroll_x, scroll_y,
                   scroll_valid, pressed_buttons, released_buttons, input ready);
    modport sink(input valid, motion_x, motion_y, motion_valid, scroll_x, scroll_y,
                 scroll_valid, pressed_buttons, released_buttons, output ready);
endinterface

[rtl/peta_front.sv]
// Front end: filter, remap, swap and invert events into commands.
module peta_front #(
    parameter int BUTTON_COUNT = 5,
    parameter int LAYER_COUNT = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    peta_event_if.sink                 i_ev,
    input  logic [2:0]                 i_flags,
    input  logic [5:0]                 i_rtype,
    input  logic [15:0]                i_rcodes,
    input  logic [31:0]                i_layer_mask,
    output logic                       o_valid,
    output peta_pkg::t_cmd             o_cmd,
    input  logic                       i_ready
);
    logic              r_valid, n_valid;
    peta_pkg::t_cmd    r_cmd, n_cmd;
    logic              keep;
    logic [9:0]        code;
    logic signed [16:0] val;
    logic              is_x, is_y;
    logic [9:0]        boff;

    assign i_ev.ready = !r_valid || i_ready;

    always_comb begin
        keep = i_ev.device_present && !i_ev.stop_verdict
            && (32'(i_ev.active_layer) < 32'(LAYER_COUNT))
            && i_layer_mask[i_ev.active_layer];
        code = i_ev.event_code;
        if (!i_rtype[5] && (i_rtype[4:0] == i_ev.event_type)) begin
            if (code == peta_pkg::CodeRelX || code == peta_pkg::CodeHwheel) begin
                if (!i_rcodes[7]) code = {2'b00, i_rcodes[7:0]};
            end else if (code == peta_pkg::CodeRelY || code == peta_pkg::CodeWheel) begin
                if (!i_rcodes[15]) code = {2'b00, i_rcodes[15:8]};
            end
        end
        if (i_flags[0]) begin
            case (code)
                peta_pkg::CodeRelX:   code = peta_pkg::CodeRelY;
                peta_pkg::CodeRelY:   code = peta_pkg::CodeRelX;
                peta_pkg::CodeWheel:  code = peta_pkg::CodeHwheel;
                peta_pkg::CodeHwheel: code = peta_pkg::CodeWheel;
                default: ;
            endcase
        end
        is_x = code == peta_pkg::CodeRelX || code == peta_pkg::CodeHwheel;
        is_y = code == peta_pkg::CodeRelY || code == peta_pkg::CodeWheel;
        val = 17'(i_ev.event_value);
        if (i_ev.event_type == peta_pkg::TypeRel
            && ((i_flags[1] && is_x) || (i_flags[2] && is_y))) begin
            val = -val;
        end
        boff = code - peta_pkg::CodeBtn0;
        n_cmd.op = peta_pkg::t_op_none;
        n_cmd.btn = boff[2:0];
        n_cmd.value = val;
        n_cmd.sync = i_ev.sync_mark;
        if (i_ev.event_type == peta_pkg::TypeRel) begin
            case (code)
                peta_pkg::CodeRelX:   n_cmd.op = peta_pkg::t_op_mx;
                peta_pkg::CodeRelY:   n_cmd.op = peta_pkg::t_op_my;
                peta_pkg::CodeHwheel: n_cmd.op = peta_pkg::t_op_sx;
                peta_pkg::CodeWheel:  n_cmd.op = peta_pkg::t_op_sy;
                default: ;
            endcase
        end else if (i_ev.event_type == peta_pkg::TypeKey) begin
            if (code >= peta_pkg::CodeBtn0 && 32'(boff) < 32'(BUTTON_COUNT)
                && boff < 10'd5) begin
                n_cmd.op = peta_pkg::t_op_btn;
            end
        end
        n_valid = r_valid && !i_ready;
        if (i_ev.valid && i_ev.ready && keep
            && (n_cmd.op != peta_pkg::t_op_none || n_cmd.sync)) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_ev.valid && i_ev.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd = r_cmd;
endmodule

[rtl/peta_queue.sv]
// Short command queue between front and back.
module peta_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  peta_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output peta_pkg::t_cmd o_cmd,
    input  logic           i_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    peta_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            wr, rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule

[rtl/peta_back.sv]
// Back end: serial scale divide, accumulate, rotate and report.
module peta_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  peta_pkg::t_cmd     i_cmd,
    output logic               o_ready,
    input  logic [15:0]        i_num,
    input  logic [15:0]        i_den,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_sin,
    peta_report_if.source      o_rep
);
    typedef enum logic [2:0] {
        t_idle, t_mul, t_div, t_acc, t_rot, t_out
    } t_state;

    t_state             r_state;
    peta_pkg::t_cmd     r_cmd;
    logic               r_neg;
    logic [32:0]        r_rem;
    logic [32:0]        r_quo;
    logic [5:0]         r_cnt;
    logic signed [15:0] r_mx, r_my, r_sx, r_sy;
    logic               r_ms, r_ss;
    logic [4:0]         r_pm, r_rm;
    logic [1:0]         r_rstep;
    logic signed [32:0] r_p0, r_p1;
    logic               r_ov;
    peta_pkg::t_report  r_rep;
    logic [15:0]        den;
    logic [33:0]        trial;
    logic [32:0]        mag;
    logic signed [15:0] v;
    logic signed [15:0] ax, ay, rx, ry;
    logic signed [33:0] sum;
    logic signed [33:0] q;
    logic signed [15:0] sat;

    assign den = (i_den == '0) ? 16'd1 : i_den;
    assign o_ready = r_state == t_idle;
    assign trial = {r_rem, r_quo[32]} - {18'd0, den};
    assign mag = r_neg ? -r_quo : r_quo;
    assign v = mag[15:0];

    always_comb begin
        ax = r_rstep[1] ? r_mx : r_sx;
        ay = r_rstep[1] ? r_my : r_sy;
        sum = 34'(r_p0) + 34'(r_p1);
        q = sum[33] ? -((-sum) >>> 14) : (sum >>> 14);
        if (q > 34'sd32767) sat = 16'sh7fff;
        else if (q < -34'sd32768) sat = -16'sh8000;
        else sat = q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_mx <= '0; r_my <= '0; r_sx <= '0; r_sy <= '0;
            r_ms <= 1'b0; r_ss <= 1'b0; r_pm <= '0; r_rm <= '0;
            r_rep <= '0;
        end else begin
            case (r_state)
                t_idle: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_state <= t_mul;
                    end
                end
                t_mul: begin
                    r_neg <= r_cmd.value[16];
                    r_quo <= 33'((r_cmd.value[16] ? -r_cmd.value : r_cmd.value))
                           * 33'(i_num);
                    r_rem <= '0;
                    r_cnt <= 6'd33;
                    r_state <= (r_cmd.op == peta_pkg::t_op_none) ? t_acc : t_div;
                end
                t_div: begin
                    if (!trial[33]) begin
                        r_rem <= trial[32:0];
                        r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[31:0], r_quo[32]};
                        r_quo <= {r_quo[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 6'd1) r_state <= t_acc;
                end
                t_acc: begin
                    case (r_cmd.op)
                        peta_pkg::t_op_mx: begin r_mx <= r_mx + v; r_ms <= 1'b1; end
                        peta_pkg::t_op_my: begin r_my <= r_my + v; r_ms <= 1'b1; end
                        peta_pkg::t_op_sx: begin r_sx <= r_sx + v; r_ss <= 1'b1; end
                        peta_pkg::t_op_sy: begin r_sy <= r_sy + v; r_ss <= 1'b1; end
                        peta_pkg::t_op_btn: begin
                            if (v > 16'sd0) r_pm[r_cmd.btn] <= 1'b1;
                            else r_rm[r_cmd.btn] <= 1'b1;
                        end
                        default: ;
                    endcase
                    r_rstep <= 2'd0;
                    r_ov <= 1'b0;
                    r_state <= r_cmd.sync ? t_rot : t_idle;
                end
                t_rot: begin
                    r_rstep <= r_rstep + 1'b1;
                    r_ov <= ~r_ov;
                    // even step: products, odd step: combine and store
                    if (!r_ov) begin
                        r_p0 <= r_rstep[0] ? 33'(i_sin * ax) : 33'(i_cos * ax);
                        r_p1 <= r_rstep[0] ? 33'(i_cos * ay) : 33'(-(i_sin * ay));
                        r_rstep <= r_rstep;
                    end else begin
                        if (i_sin != '0 && (r_rstep[1] ? r_ms : r_ss)) begin
                            case (r_rstep)
                                2'd0: r_rep.scroll_x <= sat;
                                2'd1: r_rep.scroll_y <= sat;
                                2'd2: r_rep.motion_x <= sat;
                                default: r_rep.motion_y <= sat;
                            endcase
                        end else begin
                            case (r_rstep)
                                2'd0: r_rep.scroll_x <= r_ss ? r_sx : '0;
                                2'd1: r_rep.scroll_y <= r_ss ? r_sy : '0;
                                2'd2: r_rep.motion_x <= r_ms ? r_mx : '0;
                                default: r_rep.motion_y <= r_ms ? r_my : '0;
                            endcase
                        end
                        if (r_rstep == 2'd3) begin
                            r_rep.motion_valid <= r_ms;
                            r_rep.scroll_valid <= r_ss;
                            r_rep.pressed_buttons <= r_pm;
                            r_rep.released_buttons <= r_rm;
                            r_mx <= '0; r_my <= '0; r_sx <= '0; r_sy <= '0;
                            r_ms <= 1'b0; r_ss <= 1'b0; r_pm <= '0; r_rm <= '0;
                            r_state <= t_out;
                        end
                    end
                end
                t_out: begin
                    if (o_rep.ready) r_state <= t_idle;
                end
                default: r_state <= t_idle;
            endcase
        end
    end

    assign o_rep.valid = r_state == t_out;
    assign o_rep.motion_x = r_rep.motion_x;
    assign o_rep.motion_y = r_rep.motion_y;
    assign o_rep.motion_valid = r_rep.motion_valid;
    assign o_rep.scroll_x = r_rep.scroll_x;
    assign o_rep.scroll_y = r_rep.scroll_y;
    assign o_rep.scroll_valid = r_rep.scroll_valid;
    assign o_rep.pressed_buttons = r_rep.pressed_buttons;
    assign o_rep.released_buttons = r_rep.released_buttons;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_rep.valid) else $error("ready while report pending");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rep.valid) |-> (!r_ms && !r_ss && r_pm == '0 && r_rm == '0))
        else $error("accumulators not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rep.valid && !o_rep.ready) |=> $stable(r_rep)) else $error("report moved");
endmodule

[rtl/pointer_event_transform_accumulator.sv]
// Top level of the pointer event transform accumulator.
// Events are filtered and classified by the front end, which registers each
// command, and queued two deep; the back end takes each command through a
// multiply state, a 33-step restoring divider and an accumulate state (a sync
// event that neither moves nor presses skips the divider; an event that is
// neither of these nor a sync event ends in the front end); a sync event adds
// rotation steps, each forming two 16x16 products, before its report is offered.
module pointer_event_transform_accumulator #(
    parameter int BUTTON_COUNT = 5,
    parameter int LAYER_COUNT = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    peta_event_if.sink                      i_ev,
    peta_report_if.source                   o_rep,
    input  logic                            i_cfg_we,
    input  logic [peta_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [peta_pkg::CfgDataW-1:0]   i_cfg_data
);
    logic [2:0]         r_flags;
    logic [15:0]        r_num, r_den, r_rcodes;
    logic signed [15:0] r_cos, r_sin;
    logic [5:0]         r_rtype;
    logic [31:0]        r_lmask;
    logic               f_valid, q_ready, q_valid, b_ready;
    peta_pkg::t_cmd     f_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0; r_num <= 16'd1; r_den <= 16'd1;
            r_cos <= 16'sd16384; r_sin <= '0; r_rtype <= 6'h3f;
            r_rcodes <= 16'hffff; r_lmask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                peta_pkg::RegFlags:  r_flags <= i_cfg_data[2:0];
                peta_pkg::RegNum:    r_num <= i_cfg_data[15:0];
                peta_pkg::RegDen:    r_den <= i_cfg_data[15:0];
                peta_pkg::RegCos:    r_cos <= i_cfg_data[15:0];
                peta_pkg::RegSin:    r_sin <= i_cfg_data[15:0];
                peta_pkg::RegRtype:  r_rtype <= i_cfg_data[5:0];
                peta_pkg::RegRcodes: r_rcodes <= i_cfg_data[15:0];
                peta_pkg::RegLayer:  r_lmask <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    peta_front #(.BUTTON_COUNT(BUTTON_COUNT), .LAYER_COUNT(LAYER_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_ev,
        .i_flags(r_flags), .i_rtype(r_rtype), .i_rcodes(r_rcodes),
        .i_layer_mask(r_lmask),
        .o_valid(f_valid), .o_cmd(f_cmd), .i_ready(q_ready)
    );

    peta_queue #(.DEPTH(2)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_cmd(f_cmd), .o_ready(q_ready),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_ready(b_ready)
    );

    peta_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_ready(b_ready),
        .i_num(r_num), .i_den(r_den), .i_cos(r_cos), .i_sin(r_sin), .o_rep
    );
endmodule
